// ===== design/tlp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared types, constants and helpers of the two-layer perceptron block.
// ----------------------------------------------------------------------------
package tlp_pkg;

    localparam int MAX_INPUTS  = 16;
    localparam int MAX_HIDDEN  = 16;
    localparam int MAX_OUTPUTS = 8;
    localparam int FRAC_BITS   = 12;
    localparam int RATE_BITS   = 12;

    localparam int OW_BASE     = MAX_INPUTS * MAX_HIDDEN;
    localparam int HB_BASE     = OW_BASE + MAX_HIDDEN * MAX_OUTPUTS;
    localparam int OB_BASE     = HB_BASE + MAX_HIDDEN;
    localparam int PARAM_TOTAL = OB_BASE + MAX_OUTPUTS;

    localparam int IIDX_W = $clog2(MAX_INPUTS);
    localparam int OIDX_W = $clog2(MAX_OUTPUTS);
    localparam int IDX_W  = (IIDX_W > OIDX_W) ? IIDX_W : OIDX_W;
    localparam int CID_W  = $clog2(MAX_HIDDEN);

    localparam int VAL_W      = 16;
    localparam int ERR_W      = VAL_W + 1;
    localparam int DATA_W     = 26;
    localparam int MULB_W     = VAL_W + 1;
    localparam int PROD_W     = DATA_W + MULB_W;
    localparam int SUM_W      = 32;
    localparam int NI_W       = 5;
    localparam int NH_W       = 5;
    localparam int NO_W       = 4;
    localparam int LR_W       = 13;
    localparam int ADDR_W     = 9;
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [NI_W-1:0] NI_RESET = 5'd2;
    localparam logic [NH_W-1:0] NH_RESET = 5'd4;
    localparam logic [NO_W-1:0] NO_RESET = 4'd1;
    localparam logic [LR_W-1:0] LR_RESET = 13'd410;
    localparam logic [LR_W-1:0] LR_MAX   = 13'd4096;
    localparam logic signed [ERR_W-1:0] ONE = ERR_W'(1 << FRAC_BITS);

    localparam logic [FUNC_W-1:0] FN_SET_INPUT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET_TARGET = 3'd1;
    localparam logic [FUNC_W-1:0] FN_EVALUATE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TEACH      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_WRITE      = 3'd4;
    localparam logic [FUNC_W-1:0] FN_READ       = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_INPUTS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HIDDEN  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUTPUTS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE  = 4'd3;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_FWD_H = 4'd1,
        OP_FWD_O = 4'd2,
        OP_BACK  = 4'd3,
        OP_UPD_O = 4'd4,
        OP_RATE  = 4'd5,
        OP_UPD_H = 4'd6,
        OP_WR_W  = 4'd7,
        OP_WR_O  = 4'd8,
        OP_WR_B  = 4'd9,
        OP_RD_W  = 4'd10,
        OP_RD_O  = 4'd11,
        OP_RD_B  = 4'd12
    } op_t;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [ADDR_W-1:0]       index;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]       out_index;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
        logic                    status;
    } result_t;

    typedef struct packed {
        logic                     valid;
        logic                     last;
        op_t                      op;
        logic [IDX_W-1:0]         idx;
        logic [CID_W-1:0]         sel;
        logic signed [DATA_W-1:0] data;
    } beat_t;

    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] vmax;
        logic signed [SUM_W-1:0] vmin;
        vmax = SUM_W'(32767);
        vmin = -SUM_W'(32768);
        if (v > vmax)
            return VAL_W'(vmax);
        else if (v < vmin)
            return VAL_W'(vmin);
        else
            return VAL_W'(v);
    endfunction

endpackage

// ===== design/two_layer_perceptron_train_infer_top.sv =====
// ----------------------------------------------------------------------------
// two_layer_perceptron_train_infer_top
// Two-layer step-activation perceptron with on-chip teaching.
// ----------------------------------------------------------------------------
// An item (func, index, value) is taken when start is high and busy is low.
// Each result shows on result for one cycle with result_valid high; the
// receiver cannot stall, so results never wait.
// Configuration beats (cfg_index, cfg_data) are taken while the block is idle.
// Hidden neurons sit in a chain of MAX_HIDDEN cells (16); work enters cell 0
// one beat a cycle and every cell hands its beat on each cycle.
// Set input, set target and a bad index or func give their result in the
// next cycle. An output bias read or write is served in state S_OBP without
// the chain; any other parameter read or write passes through all L = 16
// cells. Evaluate sends NI inputs and NO outputs down the chain and gives
// one result per output (NI/NO = inputs/outputs in use). Teach runs the
// forward pass, output bias update, back pass and weight and bias updates.
// Only one item is in work at a time; the chain latency sets the rate.
// Reset restores the configuration defaults and idles the block; the weight
// and vector stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module two_layer_perceptron_train_infer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  tlp_pkg::item_t                   item,
    output logic                             busy,
    output logic                             result_valid,
    output tlp_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FWDH  = 10'b0000000010,
        S_FWDO  = 10'b0000000100,
        S_DRAIN = 10'b0000001000,
        S_TK    = 10'b0000010000,
        S_BACK  = 10'b0000100000,
        S_UPDO  = 10'b0001000000,
        S_RATE  = 10'b0010000000,
        S_UPDH  = 10'b0100000000,
        S_OBP   = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        M_EVAL   = 2'd0,
        M_TEACH1 = 2'd1,
        M_TEACH2 = 2'd2,
        M_PARAM  = 2'd3
    } mode_t;

    state_t                             state_reg, state_next;
    mode_t                              mode_reg, mode_next;
    logic [tlp_pkg::IDX_W-1:0]          cnt_reg, cnt_next;
    tlp_pkg::item_t                     item_reg;
    logic [tlp_pkg::NI_W-1:0]           ni_reg;
    logic [tlp_pkg::NH_W-1:0]           nh_reg;
    logic [tlp_pkg::NO_W-1:0]           no_reg;
    logic [tlp_pkg::LR_W-1:0]           lr_reg;
    logic signed [tlp_pkg::VAL_W-1:0]   x_reg   [tlp_pkg::MAX_INPUTS];
    logic signed [tlp_pkg::VAL_W-1:0]   tgt_reg [tlp_pkg::MAX_OUTPUTS];
    logic signed [tlp_pkg::VAL_W-1:0]   ob_reg  [tlp_pkg::MAX_OUTPUTS];
    logic signed [tlp_pkg::ERR_W-1:0]   eo_reg  [tlp_pkg::MAX_OUTPUTS];
    logic signed [tlp_pkg::ERR_W-1:0]   tk_reg  [tlp_pkg::MAX_OUTPUTS];
    tlp_pkg::beat_t                     inject_reg, inject_next;
    logic                               rvalid_reg, rvalid_next;
    tlp_pkg::result_t                   result_reg, result_next;

    tlp_pkg::beat_t                     chain [tlp_pkg::MAX_HIDDEN+1];
    tlp_pkg::beat_t                     tail;
    logic [tlp_pkg::MAX_HIDDEN-1:0]     act;

    logic                               x_we, tgt_we, ob_we, eo_we, tk_we;
    logic signed [tlp_pkg::VAL_W-1:0]   ob_wdata;
    logic signed [tlp_pkg::ERR_W-1:0]   eo_wdata, tk_wdata;
    logic [tlp_pkg::OIDX_W-1:0]         cidx_o, tidx_o;
    logic [tlp_pkg::IIDX_W-1:0]         cidx_i;
    logic signed [30:0]                 tk_prod;
    logic                               out_act;
    logic                               in_take;

    logic [tlp_pkg::ADDR_W-1:0]         rel;
    logic                               is_wr;

    function automatic tlp_pkg::result_t mk_result(
        input logic [tlp_pkg::ADDR_W-1:0]      idx,
        input logic signed [tlp_pkg::VAL_W-1:0] val,
        input logic                             lst,
        input logic                             st
    );
        tlp_pkg::result_t r;
        r.out_index = idx;
        r.out_value = val;
        r.last      = lst;
        r.status    = st;
        return r;
    endfunction

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = ~busy;
    assign in_take      = start && !busy;
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    assign chain[0] = inject_reg;
    assign tail     = chain[tlp_pkg::MAX_HIDDEN];

    for (genvar g = 0; g < tlp_pkg::MAX_HIDDEN; g++)
    begin : g_cell
        assign act[g] = (tlp_pkg::NH_W'(g) < nh_reg);
        tlp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (tlp_pkg::CID_W'(g)),
            .active   (act[g]),
            .beat_in  (chain[g]),
            .beat_out (chain[g+1])
        );
    end

    assign cidx_o  = cnt_reg[tlp_pkg::OIDX_W-1:0];
    assign cidx_i  = cnt_reg[tlp_pkg::IIDX_W-1:0];
    assign tidx_o  = tail.idx[tlp_pkg::OIDX_W-1:0];
    assign tk_prod = $signed({1'b0, lr_reg}) * eo_reg[cidx_o];
    assign out_act = ~tail.data[tlp_pkg::DATA_W-1];

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        inject_next = '0;
        rvalid_next = 1'b0;
        result_next = result_reg;
        x_we        = 1'b0;
        tgt_we      = 1'b0;
        ob_we       = 1'b0;
        eo_we       = 1'b0;
        tk_we       = 1'b0;
        ob_wdata    = item_reg.value;
        tk_wdata    = tlp_pkg::ERR_W'(tk_prod >>> tlp_pkg::RATE_BITS);
        eo_wdata    = tlp_pkg::ERR_W'(tgt_reg[tidx_o]) - (out_act ? tlp_pkg::ONE : '0);
        rel         = '0;
        is_wr       = (item.func == tlp_pkg::FN_WRITE);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.func)
                        tlp_pkg::FN_SET_INPUT:
                        begin
                            x_we        = (item.index < tlp_pkg::ADDR_W'(tlp_pkg::MAX_INPUTS));
                            rvalid_next = 1'b1;
                            result_next = mk_result(item.index, '0, 1'b1, ~x_we);
                        end
                        tlp_pkg::FN_SET_TARGET:
                        begin
                            tgt_we      = (item.index < tlp_pkg::ADDR_W'(tlp_pkg::MAX_OUTPUTS));
                            rvalid_next = 1'b1;
                            result_next = mk_result(item.index, '0, 1'b1, ~tgt_we);
                        end
                        tlp_pkg::FN_EVALUATE:
                        begin
                            mode_next  = M_EVAL;
                            cnt_next   = '0;
                            state_next = S_FWDH;
                        end
                        tlp_pkg::FN_TEACH:
                        begin
                            mode_next  = M_TEACH1;
                            cnt_next   = '0;
                            state_next = S_FWDH;
                        end
                        tlp_pkg::FN_WRITE, tlp_pkg::FN_READ:
                        begin
                            inject_next.last = 1'b1;
                            inject_next.data = tlp_pkg::DATA_W'(item.value);
                            mode_next        = M_PARAM;
                            if (item.index < tlp_pkg::ADDR_W'(tlp_pkg::OW_BASE))
                            begin
                                inject_next.valid = 1'b1;
                                inject_next.op    = is_wr ? tlp_pkg::OP_WR_W : tlp_pkg::OP_RD_W;
                                inject_next.sel   = tlp_pkg::CID_W'(item.index % tlp_pkg::MAX_HIDDEN);
                                inject_next.idx   = tlp_pkg::IDX_W'(item.index / tlp_pkg::MAX_HIDDEN);
                                state_next        = S_DRAIN;
                            end
                            else if (item.index < tlp_pkg::ADDR_W'(tlp_pkg::HB_BASE))
                            begin
                                rel               = item.index - tlp_pkg::ADDR_W'(tlp_pkg::OW_BASE);
                                inject_next.valid = 1'b1;
                                inject_next.op    = is_wr ? tlp_pkg::OP_WR_O : tlp_pkg::OP_RD_O;
                                inject_next.sel   = tlp_pkg::CID_W'(rel / tlp_pkg::MAX_OUTPUTS);
                                inject_next.idx   = tlp_pkg::IDX_W'(rel % tlp_pkg::MAX_OUTPUTS);
                                state_next        = S_DRAIN;
                            end
                            else if (item.index < tlp_pkg::ADDR_W'(tlp_pkg::OB_BASE))
                            begin
                                rel               = item.index - tlp_pkg::ADDR_W'(tlp_pkg::HB_BASE);
                                inject_next.valid = 1'b1;
                                inject_next.op    = is_wr ? tlp_pkg::OP_WR_B : tlp_pkg::OP_RD_B;
                                inject_next.sel   = tlp_pkg::CID_W'(rel);
                                state_next        = S_DRAIN;
                            end
                            else if (item.index < tlp_pkg::ADDR_W'(tlp_pkg::PARAM_TOTAL))
                            begin
                                rel        = item.index - tlp_pkg::ADDR_W'(tlp_pkg::OB_BASE);
                                cnt_next   = tlp_pkg::IDX_W'(rel);
                                state_next = S_OBP;
                            end
                            else
                            begin
                                rvalid_next = 1'b1;
                                result_next = mk_result(item.index, '0, 1'b1, 1'b1);
                            end
                        end
                        default:
                        begin
                            rvalid_next = 1'b1;
                            result_next = mk_result(item.index, '0, 1'b1, 1'b1);
                        end
                    endcase
                end
            end
            S_FWDH:
            begin
                inject_next.valid = 1'b1;
                inject_next.op    = tlp_pkg::OP_FWD_H;
                inject_next.idx   = cnt_reg;
                inject_next.data  = tlp_pkg::DATA_W'(x_reg[cidx_i]);
                if (tlp_pkg::NI_W'(cnt_reg) == ni_reg - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = S_FWDO;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_FWDO:
            begin
                inject_next.valid = 1'b1;
                inject_next.op    = tlp_pkg::OP_FWD_O;
                inject_next.idx   = cnt_reg;
                inject_next.data  = tlp_pkg::DATA_W'(ob_reg[cidx_o]);
                if (tlp_pkg::NO_W'(cnt_reg) == no_reg - 1'b1)
                begin
                    inject_next.last = 1'b1;
                    cnt_next         = '0;
                    state_next       = S_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (tail.valid && tail.last)
                begin
                    case (mode_reg)
                        M_TEACH1:
                        begin
                            cnt_next   = '0;
                            state_next = S_TK;
                        end
                        M_TEACH2:
                        begin
                            rvalid_next = 1'b1;
                            result_next = mk_result('0, '0, 1'b1, 1'b0);
                            state_next  = S_IDLE;
                        end
                        M_PARAM:
                        begin
                            rvalid_next = 1'b1;
                            result_next = mk_result(item_reg.index,
                                (item_reg.func == tlp_pkg::FN_READ)
                                    ? tail.data[tlp_pkg::VAL_W-1:0] : '0,
                                1'b1, 1'b0);
                            state_next  = S_IDLE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_TK:
            begin
                tk_we    = 1'b1;
                ob_we    = 1'b1;
                ob_wdata = tlp_pkg::sat16(tlp_pkg::SUM_W'(ob_reg[cidx_o])
                                          + tlp_pkg::SUM_W'(tk_wdata));
                if (tlp_pkg::NO_W'(cnt_reg) == no_reg - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = S_BACK;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_BACK:
            begin
                inject_next.valid = 1'b1;
                inject_next.op    = tlp_pkg::OP_BACK;
                inject_next.idx   = cnt_reg;
                inject_next.data  = tlp_pkg::DATA_W'(eo_reg[cidx_o]);
                if (tlp_pkg::NO_W'(cnt_reg) == no_reg - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = S_UPDO;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_UPDO:
            begin
                inject_next.valid = 1'b1;
                inject_next.op    = tlp_pkg::OP_UPD_O;
                inject_next.idx   = cnt_reg;
                inject_next.data  = tlp_pkg::DATA_W'(tk_reg[cidx_o]);
                if (tlp_pkg::NO_W'(cnt_reg) == no_reg - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = S_RATE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_RATE:
            begin
                inject_next.valid = 1'b1;
                inject_next.op    = tlp_pkg::OP_RATE;
                inject_next.data  = tlp_pkg::DATA_W'(lr_reg);
                mode_next         = M_TEACH2;
                state_next        = S_UPDH;
            end
            S_UPDH:
            begin
                inject_next.valid = 1'b1;
                inject_next.op    = tlp_pkg::OP_UPD_H;
                inject_next.idx   = cnt_reg;
                inject_next.data  = tlp_pkg::DATA_W'(x_reg[cidx_i]);
                if (tlp_pkg::NI_W'(cnt_reg) == ni_reg - 1'b1)
                begin
                    inject_next.last = 1'b1;
                    cnt_next         = '0;
                    state_next       = S_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_OBP:
            begin
                ob_we       = (item_reg.func == tlp_pkg::FN_WRITE);
                rvalid_next = 1'b1;
                result_next = mk_result(item_reg.index,
                    (item_reg.func == tlp_pkg::FN_READ) ? ob_reg[cidx_o] : '0,
                    1'b1, 1'b0);
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // output sums leaving the chain
        if (tail.valid && (tail.op == tlp_pkg::OP_FWD_O))
        begin
            eo_we = 1'b1;
            if (mode_reg == M_EVAL)
            begin
                rvalid_next = 1'b1;
                result_next = mk_result(tlp_pkg::ADDR_W'(tidx_o),
                                        tlp_pkg::VAL_W'(out_act), tail.last, 1'b0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= M_EVAL;
            cnt_reg    <= '0;
            inject_reg <= '0;
            rvalid_reg <= 1'b0;
            ni_reg     <= tlp_pkg::NI_RESET;
            nh_reg     <= tlp_pkg::NH_RESET;
            no_reg     <= tlp_pkg::NO_RESET;
            lr_reg     <= tlp_pkg::LR_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            inject_reg <= inject_next;
            rvalid_reg <= rvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tlp_pkg::CFG_NUM_INPUTS:
                    begin
                        if (cfg_data[tlp_pkg::NI_W-1:0] == '0)
                            ni_reg <= tlp_pkg::NI_W'(1);
                        else if (cfg_data[tlp_pkg::NI_W-1:0] > tlp_pkg::NI_W'(tlp_pkg::MAX_INPUTS))
                            ni_reg <= tlp_pkg::NI_W'(tlp_pkg::MAX_INPUTS);
                        else
                            ni_reg <= cfg_data[tlp_pkg::NI_W-1:0];
                    end
                    tlp_pkg::CFG_NUM_HIDDEN:
                    begin
                        if (cfg_data[tlp_pkg::NH_W-1:0] == '0)
                            nh_reg <= tlp_pkg::NH_W'(1);
                        else if (cfg_data[tlp_pkg::NH_W-1:0] > tlp_pkg::NH_W'(tlp_pkg::MAX_HIDDEN))
                            nh_reg <= tlp_pkg::NH_W'(tlp_pkg::MAX_HIDDEN);
                        else
                            nh_reg <= cfg_data[tlp_pkg::NH_W-1:0];
                    end
                    tlp_pkg::CFG_NUM_OUTPUTS:
                    begin
                        if (cfg_data[tlp_pkg::NO_W-1:0] == '0)
                            no_reg <= tlp_pkg::NO_W'(1);
                        else if (cfg_data[tlp_pkg::NO_W-1:0] > tlp_pkg::NO_W'(tlp_pkg::MAX_OUTPUTS))
                            no_reg <= tlp_pkg::NO_W'(tlp_pkg::MAX_OUTPUTS);
                        else
                            no_reg <= cfg_data[tlp_pkg::NO_W-1:0];
                    end
                    tlp_pkg::CFG_LEARN_RATE:
                    begin
                        if (cfg_data[tlp_pkg::LR_W-1:0] > tlp_pkg::LR_MAX)
                            lr_reg <= tlp_pkg::LR_MAX;
                        else
                            lr_reg <= cfg_data[tlp_pkg::LR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (in_take)
            item_reg <= item;
        if (x_we)
            x_reg[item.index[tlp_pkg::IIDX_W-1:0]] <= item.value;
        if (tgt_we)
            tgt_reg[item.index[tlp_pkg::OIDX_W-1:0]] <= item.value;
        if (ob_we)
            ob_reg[cidx_o] <= ob_wdata;
        if (eo_we)
            eo_reg[tidx_o] <= eo_wdata;
        if (tk_we)
            tk_reg[cidx_o] <= tk_wdata;
    end

endmodule

// ===== design/tlp_cell.sv =====
// ----------------------------------------------------------------------------
// tlp_cell
// One hidden neuron: its input weights, bias and output weights, with one
// shared multiplier; acts on each beat and hands it to the next cell.
// ----------------------------------------------------------------------------
module tlp_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tlp_pkg::CID_W-1:0]   cell_id,
    input  logic                        active,
    input  tlp_pkg::beat_t              beat_in,
    output tlp_pkg::beat_t              beat_out
);

    logic signed [tlp_pkg::VAL_W-1:0]  w_reg  [tlp_pkg::MAX_INPUTS];
    logic signed [tlp_pkg::VAL_W-1:0]  ow_reg [tlp_pkg::MAX_OUTPUTS];
    logic signed [tlp_pkg::VAL_W-1:0]  b_reg;
    logic signed [tlp_pkg::DATA_W-1:0] acc_reg, acc_next;
    logic signed [tlp_pkg::DATA_W-1:0] eh_reg, eh_next;
    logic signed [tlp_pkg::DATA_W-1:0] t_reg, t_next;
    logic                              hid_reg, hid_next;
    tlp_pkg::beat_t                    beat_reg, beat_next;

    logic [tlp_pkg::IIDX_W-1:0]        iidx;
    logic [tlp_pkg::OIDX_W-1:0]        oidx;
    logic                              mine;
    logic signed [tlp_pkg::DATA_W-1:0] mul_a;
    logic signed [tlp_pkg::MULB_W-1:0] mul_b;
    logic signed [tlp_pkg::PROD_W-1:0] prod;
    logic signed [tlp_pkg::SUM_W-1:0]  term;
    logic                              w_we, ow_we, b_we;
    logic signed [tlp_pkg::VAL_W-1:0]  w_wdata, ow_wdata, b_wdata;

    assign iidx     = beat_in.idx[tlp_pkg::IIDX_W-1:0];
    assign oidx     = beat_in.idx[tlp_pkg::OIDX_W-1:0];
    assign mine     = (beat_in.sel == cell_id);
    assign beat_out = beat_reg;

    always_comb
    begin
        case (beat_in.op)
            tlp_pkg::OP_FWD_H:
            begin
                mul_a = beat_in.data;
                mul_b = tlp_pkg::MULB_W'(w_reg[iidx]);
            end
            tlp_pkg::OP_BACK:
            begin
                mul_a = beat_in.data;
                mul_b = tlp_pkg::MULB_W'(ow_reg[oidx]);
            end
            tlp_pkg::OP_RATE:
            begin
                mul_a = eh_reg;
                mul_b = $signed(beat_in.data[tlp_pkg::MULB_W-1:0]);
            end
            tlp_pkg::OP_UPD_H:
            begin
                mul_a = t_reg;
                mul_b = $signed(beat_in.data[tlp_pkg::MULB_W-1:0]);
            end
            default:
            begin
                mul_a = beat_in.data;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
        if (beat_in.op == tlp_pkg::OP_RATE)
            term = tlp_pkg::SUM_W'(prod >>> tlp_pkg::RATE_BITS);
        else
            term = tlp_pkg::SUM_W'(prod >>> tlp_pkg::FRAC_BITS);
    end

    always_comb
    begin
        beat_next = beat_in;
        acc_next  = acc_reg;
        eh_next   = eh_reg;
        t_next    = t_reg;
        hid_next  = hid_reg;
        w_we      = 1'b0;
        ow_we     = 1'b0;
        b_we      = 1'b0;
        w_wdata   = beat_in.data[tlp_pkg::VAL_W-1:0];
        ow_wdata  = beat_in.data[tlp_pkg::VAL_W-1:0];
        b_wdata   = beat_in.data[tlp_pkg::VAL_W-1:0];
        if (beat_in.valid)
        begin
            case (beat_in.op)
                tlp_pkg::OP_FWD_H:
                begin
                    acc_next = ((iidx == '0) ? tlp_pkg::DATA_W'(b_reg) : acc_reg)
                             + term[tlp_pkg::DATA_W-1:0];
                    hid_next = ~acc_next[tlp_pkg::DATA_W-1];
                end
                tlp_pkg::OP_FWD_O:
                begin
                    if (active && hid_reg)
                        beat_next.data = beat_in.data + tlp_pkg::DATA_W'(ow_reg[oidx]);
                end
                tlp_pkg::OP_BACK:
                begin
                    eh_next = ((oidx == '0) ? '0 : eh_reg) + term[tlp_pkg::DATA_W-1:0];
                end
                tlp_pkg::OP_UPD_O:
                begin
                    ow_we    = active && hid_reg;
                    ow_wdata = tlp_pkg::sat16(tlp_pkg::SUM_W'(ow_reg[oidx])
                                              + tlp_pkg::SUM_W'(beat_in.data));
                end
                tlp_pkg::OP_RATE:
                begin
                    t_next  = term[tlp_pkg::DATA_W-1:0];
                    b_we    = active;
                    b_wdata = tlp_pkg::sat16(tlp_pkg::SUM_W'(b_reg) + term);
                end
                tlp_pkg::OP_UPD_H:
                begin
                    w_we    = active;
                    w_wdata = tlp_pkg::sat16(tlp_pkg::SUM_W'(w_reg[iidx]) + term);
                end
                tlp_pkg::OP_WR_W: w_we  = mine;
                tlp_pkg::OP_WR_O: ow_we = mine;
                tlp_pkg::OP_WR_B: b_we  = mine;
                tlp_pkg::OP_RD_W:
                begin
                    if (mine)
                        beat_next.data = tlp_pkg::DATA_W'(w_reg[iidx]);
                end
                tlp_pkg::OP_RD_O:
                begin
                    if (mine)
                        beat_next.data = tlp_pkg::DATA_W'(ow_reg[oidx]);
                end
                tlp_pkg::OP_RD_B:
                begin
                    if (mine)
                        beat_next.data = tlp_pkg::DATA_W'(b_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beat_reg <= '0;
        else
            beat_reg <= beat_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        eh_reg  <= eh_next;
        t_reg   <= t_next;
        hid_reg <= hid_next;
        if (w_we)
            w_reg[iidx] <= w_wdata;
        if (ow_we)
            ow_reg[oidx] <= ow_wdata;
        if (b_we)
            b_reg <= b_wdata;
    end

endmodule

// ===== design/tlp_checker.sv =====
// ----------------------------------------------------------------------------
// tlp_checker
// Port-level checks of the perceptron block, bound to the top level.
// ----------------------------------------------------------------------------
module tlp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input tlp_pkg::item_t            item,
    input logic                      busy,
    input logic                      result_valid,
    input tlp_pkg::result_t          result
);

    a_long_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.func == tlp_pkg::FN_EVALUATE
                            || item.func == tlp_pkg::FN_TEACH)) |=> busy)
        else $error("evaluate or teach did not raise busy");

    a_set_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.func == tlp_pkg::FN_SET_INPUT
                            || item.func == tlp_pkg::FN_SET_TARGET))
        |=> (result_valid && result.last && !busy))
        else $error("set item did not finish in one beat");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status) |-> (result.out_value == '0))
        else $error("error result carries a value");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && result.last))
        else $error("item ended without a final result");

endmodule

bind two_layer_perceptron_train_infer_top tlp_checker u_tlp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
